@@ sv/calibrated_wiper_lookup_ramp_core_defines.svh @@
// Assertion macros used by the checker file of the wiper lookup core.
`ifndef CALIBRATED_WIPER_LOOKUP_RAMP_CORE_DEFINES_SVH
`define CALIBRATED_WIPER_LOOKUP_RAMP_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CWLR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwlr check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CWLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwlr check failed one cycle later");

`endif

@@ sv/cwlr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cwlr_pkg;

	// Item kinds on the func port.
	typedef enum logic [1:0] {
		FN_CAL_START  = 2'd0,
		FN_CAL_SAMPLE = 2'd1,
		FN_SET_TARGET = 2'd2,
		FN_TICK       = 2'd3
	} func_t;

	// Sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EXEC  = 9'b000000010,
		ST_S_RD  = 9'b000000100,
		ST_S_CMP = 9'b000001000,
		ST_F_RDA = 9'b000010000,
		ST_F_RDB = 9'b000100000,
		ST_F_CMP = 9'b001000000,
		ST_V_RD  = 9'b010000000,
		ST_V_OUT = 9'b100000000
	} state_t;

	localparam int WIPER_W = 8;
	localparam int VOUT_W  = 16;
	localparam int CFG_W   = 16;

	typedef logic [WIPER_W-1:0] wiper_t;

endpackage

`default_nettype wire

@@ sv/cwlr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cwlr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/calibrated_wiper_lookup_ramp_core.sv @@
// Channel       Handshake               Payload
// command in    start, busy             func, voltage_code
// result out    done (one cycle)        write_strobe, wiper_value, voltage_at_wiper,
//                                       table_ready, lookup_wiper, at_target
// config        cfg_wr_en               cfg_wr_data (ramp_step_ticks)
//
// Start, sample and tick transactions pass through EXEC, V_RD and V_OUT before the next acceptance.
// A target request on a calibrated table runs a binary search through the single read
// port of the table memory: each halving passes through S_RD and S_CMP, and a neighbor
// check in F_RDA, F_RDB and F_CMP follows when the lower bound is not the first entry.
// Reset clears all control state; table contents are undefined until sampled.
// Each result is shown for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module calibrated_wiper_lookup_ramp_core #(
	parameter int POS_MIN    = 0,
	parameter int POS_MAX    = 127,
	parameter int VOLT_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [1:0]                func,
	input  wire logic [15:0]               voltage_code,
	input  wire logic                      cfg_wr_en,
	input  wire logic [cwlr_pkg::CFG_W-1:0] cfg_wr_data,
	output logic                           done,
	output logic                           write_strobe,
	output cwlr_pkg::wiper_t               wiper_value,
	output logic [cwlr_pkg::VOUT_W-1:0]    voltage_at_wiper,
	output logic                           table_ready,
	output cwlr_pkg::wiper_t               lookup_wiper,
	output logic                           at_target
);

	import cwlr_pkg::*;

	localparam int TABLE_LEN = POS_MAX - POS_MIN + 1;
	localparam int ADDR_W    = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;
	localparam int CNT_W     = $clog2(TABLE_LEN + 1);
	localparam int VW        = VOLT_WIDTH;
	localparam logic [CNT_W-1:0]   TABLE_LEN_C = CNT_W'(TABLE_LEN);
	localparam logic [ADDR_W-1:0]  LAST_IDX    = ADDR_W'(TABLE_LEN - 1);
	localparam wiper_t             PMIN8       = WIPER_W'(POS_MIN);
	localparam wiper_t             PMAX8       = WIPER_W'(POS_MAX);
	localparam logic [WIPER_W:0]   PMIN9       = (WIPER_W + 1)'(POS_MIN);
	localparam logic [WIPER_W:0]   PMAX9       = (WIPER_W + 1)'(POS_MAX);

	state_t               state_q;
	func_t                func_q;
	logic [VW-1:0]        volt_in_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 cal_q;
	wiper_t               cur_q;
	wiper_t               tgt_q;
	logic [CFG_W-1:0]     ramp_cnt_q;
	logic [CFG_W-1:0]     step_q;
	logic                 strobe_q;
	logic [ADDR_W-1:0]    lo_q;
	logic [ADDR_W-1:0]    hi_q;
	logic [VW-1:0]        above_val_q;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [VW-1:0]        ram_rdata;
	logic [ADDR_W:0]      mid_sum;
	logic [ADDR_W-1:0]    mid;
	logic [VW+15:0]       volt_in_wide;
	logic [VW+15:0]       rdata_wide;
	logic [CNT_W-1:0]     cnt_nxt;
	logic [WIPER_W:0]     inc9;
	wiper_t               dec8;
	wiper_t               step_up;
	wiper_t               step_dn;
	logic                 cur_in_range;
	logic [ADDR_W-1:0]    cur_idx;
	logic signed [VW+1:0] dist_below;
	logic signed [VW+1:0] dist_above;
	wiper_t               lo_wiper;

	// Input voltage is kept as VOLT_WIDTH bits; read data goes out as 16 bits.
	assign volt_in_wide = {{VW{1'b0}}, voltage_code};
	assign rdata_wide   = {16'b0, ram_rdata};

	// Midpoint of the current search window.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[ADDR_W:1];

	// Next fill count after a sample.
	assign cnt_nxt = cnt_q + 1'b1;

	// Clamped neighbors of the current wiper for ramp steps.
	assign inc9    = {1'b0, cur_q} + 1'b1;
	assign dec8    = cur_q - 1'b1;
	assign step_up = (inc9 > PMAX9) ? PMAX8 : ((inc9 < PMIN9) ? PMIN8 : inc9[WIPER_W-1:0]);
	assign step_dn = (cur_q <= PMIN8) ? PMIN8 : ((dec8 > PMAX8) ? PMAX8 : dec8);

	// Table index of the current wiper.
	assign cur_in_range = (cur_q >= PMIN8) && (cur_q <= PMAX8);
	assign cur_idx      = ADDR_W'(cur_q - PMIN8);

	// Signed distances to the entry at the lower bound and the entry below it.
	assign dist_below = $signed({2'b0, volt_in_q}) - $signed({2'b0, ram_rdata});
	assign dist_above = $signed({2'b0, above_val_q}) - $signed({2'b0, volt_in_q});

	// Wiper position of the search result.
	assign lo_wiper = WIPER_W'(PMIN9 + (WIPER_W + 1)'(lo_q));

	assign busy = (state_q != ST_IDLE);

	// Memory write on an accepted calibration sample.
	assign ram_we = (state_q == ST_EXEC) && (func_q == FN_CAL_SAMPLE) && !cal_q &&
		(cnt_q < TABLE_LEN_C);

	// Read address selection by sequencer state.
	always_comb begin
		case (state_q)
			ST_S_RD:  ram_raddr = mid;
			ST_F_RDA: ram_raddr = lo_q;
			ST_F_RDB: ram_raddr = lo_q - 1'b1;
			ST_V_RD:  ram_raddr = cur_idx;
			default:  ram_raddr = '0;
		endcase
	end

	cwlr_ram #(
		.WIDTH (VW),
		.DEPTH (TABLE_LEN),
		.AW    (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (volt_in_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cfg_wr_en) begin
			step_q <= cfg_wr_data;
		end
	end

	// Transaction payload latched at acceptance.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_q    <= func_t'(func);
			volt_in_q <= volt_in_wide[VW-1:0];
		end
	end

	// Sequencer and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			cal_q      <= 1'b0;
			cur_q      <= WIPER_W'(1);
			tgt_q      <= WIPER_W'(1);
			ramp_cnt_q <= '0;
			strobe_q   <= 1'b0;
			lo_q       <= '0;
			hi_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					strobe_q <= 1'b0;
					state_q  <= ST_V_RD;
					case (func_q)
						FN_CAL_START: begin
							cnt_q      <= '0;
							cal_q      <= 1'b0;
							cur_q      <= PMIN8;
							tgt_q      <= PMIN8;
							ramp_cnt_q <= '0;
							strobe_q   <= 1'b1;
						end
						FN_CAL_SAMPLE: begin
							if (ram_we) begin
								cnt_q    <= cnt_nxt;
								strobe_q <= 1'b1;
								if (cnt_nxt < TABLE_LEN_C) begin
									cur_q <= WIPER_W'(PMIN9 + (WIPER_W + 1)'(cnt_nxt));
								end else begin
									cal_q <= 1'b1;
									cur_q <= PMIN8;
									tgt_q <= PMIN8;
								end
							end
						end
						FN_SET_TARGET: begin
							if (cal_q) begin
								ramp_cnt_q <= step_q;
								lo_q       <= '0;
								hi_q       <= LAST_IDX;
								state_q    <= ST_S_RD;
							end
						end
						default: begin
							if (cal_q && (cur_q != tgt_q)) begin
								if (ramp_cnt_q >= step_q) begin
									cur_q      <= (cur_q < tgt_q) ? step_up : step_dn;
									ramp_cnt_q <= '0;
									strobe_q   <= 1'b1;
								end else begin
									ramp_cnt_q <= ramp_cnt_q + 1'b1;
								end
							end
						end
					endcase
				end
				ST_S_RD: begin
					// Issue the midpoint read, or leave the search loop.
					if (lo_q < hi_q) begin
						state_q <= ST_S_CMP;
					end else if (lo_q != '0) begin
						state_q <= ST_F_RDA;
					end else begin
						tgt_q   <= lo_wiper;
						state_q <= ST_V_RD;
					end
				end
				ST_S_CMP: begin
					if (ram_rdata < volt_in_q) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
					state_q <= ST_S_RD;
				end
				ST_F_RDA: begin
					state_q <= ST_F_RDB;
				end
				ST_F_RDB: begin
					state_q <= ST_F_CMP;
				end
				ST_F_CMP: begin
					// Ties between the two neighbors go to the upper entry.
					if (dist_below < dist_above) begin
						tgt_q <= WIPER_W'(lo_wiper - 1'b1);
					end else begin
						tgt_q <= lo_wiper;
					end
					state_q <= ST_V_RD;
				end
				ST_V_RD: begin
					state_q <= ST_V_OUT;
				end
				ST_V_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Upper neighbor value captured in F_RDB, as its read data returns.
	always_ff @(posedge clk) begin
		if (state_q == ST_F_RDB) begin
			above_val_q <= ram_rdata;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_V_OUT);
		end
	end

	// Result registers, loaded as the table read returns.
	always_ff @(posedge clk) begin
		if (state_q == ST_V_OUT) begin
			write_strobe     <= strobe_q;
			wiper_value      <= cur_q;
			voltage_at_wiper <= (cal_q && cur_in_range) ? rdata_wide[VOUT_W-1:0] : '0;
			table_ready      <= cal_q;
			lookup_wiper     <= tgt_q;
			at_target        <= (cur_q == tgt_q);
		end
	end

endmodule

`default_nettype wire

@@ sv/cwlr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "calibrated_wiper_lookup_ramp_core_defines.svh"

module cwlr_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire logic                table_ready,
	input wire logic                at_target,
	input wire cwlr_pkg::wiper_t    wiper_value,
	input wire cwlr_pkg::wiper_t    lookup_wiper,
	input wire logic [15:0]         voltage_at_wiper
);

	// Every accepted transaction makes the block busy in the following cycle.
	`CWLR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// A result is shown for a single cycle.
	`CWLR_ASSERT_NEXT(a_done_single, done, !done)

	// The target flag agrees with the reported positions.
	`CWLR_ASSERT_NOW(a_at_target, done, at_target == (wiper_value == lookup_wiper))

	// An uncalibrated table reports no voltage.
	`CWLR_ASSERT_NOW(a_uncal_zero, done && !table_ready, voltage_at_wiper == 16'd0)

endmodule

bind calibrated_wiper_lookup_ramp_core cwlr_checker u_cwlr_checker (.*);

`default_nettype wire
